/* hw/rtl/rmr_pkg.sv */
// Shared types, constants and tables for the rotation-matrix-from-rate unit.
// No dependencies.
package rmr_pkg;

    localparam int DW = 32;
    localparam logic signed [34:0] ONE_Q30      = 35'sh040000000;
    localparam logic signed [34:0] PI_Q30       = 35'sh0C90FDAA2;
    localparam logic signed [34:0] HALF_PI_Q30  = 35'sh06487ED51;
    localparam logic signed [34:0] TWO_PI_Q30   = 35'sh1921FB544;
    localparam logic [55:0]        TWO_PI_Q52   = 56'h6487ED5110B461;
    localparam logic signed [34:0] GAIN_Q30     = 35'sh026DD3B6A;
    localparam int ATAN_ENTRIES = 40;

    // Truncated arctangent table, Q2.30
    function automatic logic signed [34:0] atan_q30(input logic [5:0] i);
        logic signed [34:0] v;
        case (i)
            6'd0:  v = 35'sh3243F6A8;
            6'd1:  v = 35'sh1DAC6705;
            6'd2:  v = 35'sh0FADBAFC;
            6'd3:  v = 35'sh07F56EA6;
            6'd4:  v = 35'sh03FEAB76;
            6'd5:  v = 35'sh01FFD55B;
            6'd6:  v = 35'sh00FFFAAA;
            6'd7:  v = 35'sh007FFF55;
            6'd8:  v = 35'sh003FFFEA;
            6'd9:  v = 35'sh001FFFFD;
            6'd10: v = 35'sh000FFFFF;
            6'd11: v = 35'sh0007FFFF;
            6'd12: v = 35'sh0003FFFF;
            6'd13: v = 35'sh0001FFFF;
            6'd14: v = 35'sh0000FFFF;
            6'd15: v = 35'sh00007FFF;
            6'd16: v = 35'sh00003FFF;
            6'd17: v = 35'sh00001FFF;
            6'd18: v = 35'sh00000FFF;
            6'd19: v = 35'sh000007FF;
            6'd20: v = 35'sh000003FF;
            6'd21: v = 35'sh000001FF;
            6'd22: v = 35'sh000000FF;
            6'd23: v = 35'sh0000007F;
            6'd24: v = 35'sh0000003F;
            6'd25: v = 35'sh0000001F;
            6'd26: v = 35'sh0000000F;
            6'd27: v = 35'sh00000007;
            6'd28: v = 35'sh00000003;
            6'd29: v = 35'sh00000001;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Word carried alongside the staged math as far as the unit-vector dividers
    typedef struct packed {
        logic signed [31:0] wx;
        logic signed [31:0] wy;
        logic signed [31:0] wz;
        logic        [31:0] t;
    } rmr_in_t;

endpackage

/* hw/rtl/rmr_sqrt.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on rmr_pkg.
module rmr_sqrt #(
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [63:0]      in_rad,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_root,
    output logic [TAG_W-1:0] out_tag
);
    import rmr_pkg::*;

    localparam int STG = 32;

    logic [63:0]      rem_reg  [STG+1];
    logic [31:0]      root_reg [STG+1];
    logic [TAG_W-1:0] tag_reg  [STG+1];
    logic [STG:0]     vld_reg;

    assign rem_reg[0]  = in_rad;
    assign root_reg[0] = '0;
    assign tag_reg[0]  = in_tag;
    assign vld_reg[0]  = in_valid;

    // Restoring method: test bit k of the root at stage 31-k
    for (genvar g = 0; g < STG; g++) begin : g_stage
        localparam int K = STG - 1 - g;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [31:0] root_next;
        always_comb
        begin
            trial = ({32'd0, root_reg[g]} << (K + 1)) + (64'd1 << (2 * K));
            if (rem_reg[g] >= trial)
            begin
                rem_next  = rem_reg[g] - trial;
                root_next = root_reg[g] | (32'd1 << K);
            end
            else
            begin
                rem_next  = rem_reg[g];
                root_next = root_reg[g];
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (en)
                vld_reg[g+1] <= vld_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1]  <= rem_next;
                root_reg[g+1] <= root_next;
                tag_reg[g+1]  <= tag_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[STG];
    assign out_root  = root_reg[STG];
    assign out_tag   = tag_reg[STG];
endmodule

/* hw/rtl/rmr_cordic.sv */
// Pipelined rotation-mode CORDIC giving sin and cos in Q2.30, one step per stage.
// Depends on rmr_pkg.
module rmr_cordic #(
    parameter int ITER  = 30,
    parameter int TAG_W = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic signed [34:0] in_ang,
    input  logic               in_neg,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic signed [34:0] out_sin,
    output logic signed [34:0] out_cos,
    output logic [TAG_W-1:0]   out_tag
);
    import rmr_pkg::*;

    localparam int N = (ITER < ATAN_ENTRIES) ? ITER : ATAN_ENTRIES;

    logic signed [34:0] x_reg [N+1];
    logic signed [34:0] y_reg [N+1];
    logic signed [34:0] z_reg [N+1];
    logic               neg_reg [N+1];
    logic [TAG_W-1:0]   tag_reg [N+1];
    logic [N:0]         vld_reg;

    assign x_reg[0]   = GAIN_Q30;
    assign y_reg[0]   = '0;
    assign z_reg[0]   = in_ang;
    assign neg_reg[0] = in_neg;
    assign tag_reg[0] = in_tag;
    assign vld_reg[0] = in_valid;

    for (genvar g = 0; g < N; g++) begin : g_iter
        logic signed [34:0] dx;
        logic signed [34:0] dy;
        assign dx = y_reg[g] >>> g;
        assign dy = x_reg[g] >>> g;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (en)
                vld_reg[g+1] <= vld_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!z_reg[g][34])
                begin
                    x_reg[g+1] <= x_reg[g] - dx;
                    y_reg[g+1] <= y_reg[g] + dy;
                    z_reg[g+1] <= z_reg[g] - atan_q30(6'(g));
                end
                else
                begin
                    x_reg[g+1] <= x_reg[g] + dx;
                    y_reg[g+1] <= y_reg[g] - dy;
                    z_reg[g+1] <= z_reg[g] + atan_q30(6'(g));
                end
                neg_reg[g+1] <= neg_reg[g];
                tag_reg[g+1] <= tag_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_sin   = neg_reg[N] ? -y_reg[N] : y_reg[N];
    assign out_cos   = neg_reg[N] ? -x_reg[N] : x_reg[N];
    assign out_tag   = tag_reg[N];
endmodule

/* hw/rtl/rmr_div.sv */
// Pipelined restoring divider: quotient = floor(num / den), one bit per stage.
// Depends on rmr_pkg.
module rmr_div #(
    parameter int TAG_W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [62:0]      in_num,
    input  logic [31:0]      in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [62:0]      out_quo,
    output logic [TAG_W-1:0] out_tag
);
    import rmr_pkg::*;

    localparam int QB = 63;

    // Remainder stays below den, so 33 bits suffice
    logic [32:0]      rem_reg [QB+1];
    logic [62:0]      num_reg [QB+1];
    logic [31:0]      den_reg [QB+1];
    logic [TAG_W-1:0] tag_reg [QB+1];
    logic [QB:0]      vld_reg;

    assign rem_reg[0] = '0;
    assign num_reg[0] = in_num;
    assign den_reg[0] = in_den;
    assign tag_reg[0] = in_tag;
    assign vld_reg[0] = in_valid;

    // Shift one dividend bit in per stage; num_reg becomes the quotient
    for (genvar g = 0; g < QB; g++) begin : g_bit
        logic [33:0] sh;
        logic        ge;
        assign sh = {rem_reg[g], num_reg[g][QB-1]};
        assign ge = sh >= {2'b00, den_reg[g]};
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g+1] <= 1'b0;
            else if (en)
                vld_reg[g+1] <= vld_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[g+1] <= ge ? 33'(sh - {2'b00, den_reg[g]}) : sh[32:0];
                num_reg[g+1] <= {num_reg[g][QB-2:0], ge};
                den_reg[g+1] <= den_reg[g];
                tag_reg[g+1] <= tag_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[QB];
    assign out_quo   = num_reg[QB];
    assign out_tag   = tag_reg[QB];
endmodule

/* hw/rtl/rotation_matrix_from_rate_unit.sv */
// Rotation matrix from angular rate (Rodrigues form), streaming pipeline.
// Depends on rmr_pkg, rmr_sqrt, rmr_cordic, rmr_div.
//
// Accepts one rate/time-step word per clock and returns one matrix word per
// input, in order. The pipe is 144 register stages deep with the default
// CORDIC_ITERATIONS of 30. The stages are:
//   - two for squaring and summing;
//   - 32 for the square root;
//   - two for n * t;
//   - ten for the reduction modulo 2pi;
//   - one per CORDIC iteration;
//   - 63 for the unit-vector dividers that follow the CORDIC;
//   - five product/sum stages ending in the output register.
// One word per clock is sustained while the receiver takes every output
// word. The whole pipe advances together, so it stalls as a unit whenever
// the word in the output register is held by the receiver.
module rotation_matrix_from_rate_unit #(
    parameter int DATA_WIDTH        = 32,
    parameter int CORDIC_ITERATIONS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] rate_x,
    input  logic signed [31:0] rate_y,
    input  logic signed [31:0] rate_z,
    input  logic [31:0]        time_step,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] r11,
    output logic signed [31:0] r12,
    output logic signed [31:0] r13,
    output logic signed [31:0] r21,
    output logic signed [31:0] r22,
    output logic signed [31:0] r23,
    output logic signed [31:0] r31,
    output logic signed [31:0] r32,
    output logic signed [31:0] r33,
    output logic               is_identity
);
    import rmr_pkg::*;

    localparam int IN_W = $bits(rmr_in_t);
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    // Whole pipe moves when the output register can take a word
    logic en;
    logic out_valid_reg;
    logic tail_valid;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Threshold register
    logic [30:0] thr_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= '0;
        else if (cfg_valid)
            thr_reg <= cfg_data;
    end

    // Stage A: magnitudes squared
    rmr_in_t       a_in_reg;
    logic          a_vld_reg;
    logic [63:0]   a_sq_reg [3];
    logic [31:0]   mag [3];
    assign mag[0] = rate_x[31] ? 32'(-rate_x) : rate_x;
    assign mag[1] = rate_y[31] ? 32'(-rate_y) : rate_y;
    assign mag[2] = rate_z[31] ? 32'(-rate_z) : rate_z;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (en)
            a_vld_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_in_reg <= '{wx: rate_x, wy: rate_y, wz: rate_z, t: time_step};
            for (int i = 0; i < 3; i++)
                a_sq_reg[i] <= mag[i] * mag[i];
        end
    end

    // Stage B: sum of squares (each square is at most 2^62, so the sum of
    // three stays below 2^64)
    rmr_in_t     b_in_reg;
    logic        b_vld_reg;
    logic [63:0] b_sum_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (en)
            b_vld_reg <= a_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_in_reg  <= a_in_reg;
            b_sum_reg <= a_sq_reg[0] + a_sq_reg[1] + a_sq_reg[2];
        end
    end

    // Norm
    logic        n_vld;
    logic [31:0] n_root;
    logic [IN_W-1:0] n_tag;
    rmr_in_t     n_in;
    rmr_sqrt #(.TAG_W(IN_W)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(b_vld_reg), .in_rad(b_sum_reg), .in_tag(b_in_reg),
        .out_valid(n_vld), .out_root(n_root), .out_tag(n_tag)
    );
    assign n_in = rmr_in_t'(n_tag);

    // Stage C: n * t (64 bits), cut as two 32x16 partial products
    logic        c_vld_reg;
    rmr_in_t     c_in_reg;
    logic [31:0] c_n_reg;
    logic [47:0] c_lo_reg;
    logic [47:0] c_hi_reg;
    logic        c_id_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_vld_reg <= 1'b0;
        else if (en)
            c_vld_reg <= n_vld;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_in_reg <= n_in;
            c_n_reg  <= n_root;
            c_lo_reg <= n_root * n_in.t[15:0];
            c_hi_reg <= n_root * n_in.t[31:16];
            c_id_reg <= {1'b0, n_root} <= {2'b00, thr_reg};
        end
    end

    // Stage D: combine product
    logic        d_vld_reg;
    rmr_in_t     d_in_reg;
    logic [31:0] d_n_reg;
    logic [63:0] d_p_reg;
    logic        d_id_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (en)
            d_vld_reg <= c_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_in_reg <= c_in_reg;
            d_n_reg  <= c_n_reg;
            d_id_reg <= c_id_reg;
            d_p_reg  <= {16'd0, c_lo_reg} + {c_hi_reg, 16'd0};
        end
    end

    // Reduction mod 2pi: product < 2^64, 2pi*2^52 ~ 2^54.65, so quotient < 2^10.
    // Ten compare/subtract stages, one quotient bit each.
    localparam int RS = 10;
    logic [63:0]  red_reg [RS+1];
    rmr_in_t      red_in_reg [RS+1];
    logic [31:0]  red_n_reg [RS+1];
    logic         red_id_reg [RS+1];
    logic [RS:0]  red_vld_reg;
    assign red_reg[0]     = d_p_reg;
    assign red_in_reg[0]  = d_in_reg;
    assign red_n_reg[0]   = d_n_reg;
    assign red_id_reg[0]  = d_id_reg;
    assign red_vld_reg[0] = d_vld_reg;
    for (genvar g = 0; g < RS; g++) begin : g_red
        localparam int K = RS - 1 - g;
        logic [65:0] m;
        assign m = {10'd0, TWO_PI_Q52} << K;
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                red_vld_reg[g+1] <= 1'b0;
            else if (en)
                red_vld_reg[g+1] <= red_vld_reg[g];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_reg[g+1]    <= ({2'b00, red_reg[g]} >= m)
                                   ? 64'({2'b00, red_reg[g]} - m) : red_reg[g];
                red_in_reg[g+1] <= red_in_reg[g];
                red_n_reg[g+1]  <= red_n_reg[g];
                red_id_reg[g+1] <= red_id_reg[g];
            end
        end
    end

    // Stage E: angle fold into [-pi/2, pi/2]
    logic signed [34:0] e_a;
    logic signed [34:0] e_ang;
    logic               e_neg;
    always_comb
    begin
        e_a   = $signed({1'b0, red_reg[RS][55:22]});
        e_neg = 1'b0;
        if (e_a > PI_Q30)
            e_a = e_a - TWO_PI_Q30;
        e_ang = e_a;
        if (e_a > HALF_PI_Q30)
        begin
            e_ang = e_a - PI_Q30;
            e_neg = 1'b1;
        end
        else if (e_a < -HALF_PI_Q30)
        begin
            e_ang = e_a + PI_Q30;
            e_neg = 1'b1;
        end
    end

    // Side word that follows the CORDIC: rates, norm, identity flag
    localparam int SW = IN_W + 33;
    logic [SW-1:0] cs_tag;
    logic          cs_vld;
    logic signed [34:0] cs_sin;
    logic signed [34:0] cs_cos;
    rmr_cordic #(.ITER(CORDIC_ITERATIONS), .TAG_W(SW)) u_cordic (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(red_vld_reg[RS]), .in_ang(e_ang), .in_neg(e_neg),
        .in_tag({red_in_reg[RS], red_n_reg[RS], red_id_reg[RS]}),
        .out_valid(cs_vld), .out_sin(cs_sin), .out_cos(cs_cos), .out_tag(cs_tag)
    );

    rmr_in_t     f_in;
    logic [31:0] f_n;
    logic        f_id;
    assign {f_in, f_n, f_id} = cs_tag;

    // Unit vector: three dividers side by side
    localparam int DT = 1 + 1 + 35 + 35;
    logic [62:0] num [3];
    logic [31:0] wabs [3];
    logic [2:0]  wsg;
    assign wsg  = {f_in.wz[31], f_in.wy[31], f_in.wx[31]};
    assign wabs[0] = f_in.wx[31] ? 32'(-f_in.wx) : f_in.wx;
    assign wabs[1] = f_in.wy[31] ? 32'(-f_in.wy) : f_in.wy;
    assign wabs[2] = f_in.wz[31] ? 32'(-f_in.wz) : f_in.wz;
    logic [62:0] q_quo [3];
    logic [2:0]  q_vld;
    logic [DT+2:0] q_tag [3];
    for (genvar g = 0; g < 3; g++) begin : g_div
        assign num[g] = {wabs[g], 30'd0} + {32'd0, f_n[31:1]};
        rmr_div #(.TAG_W(DT + 3)) u_div (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(cs_vld), .in_num(num[g]),
            .in_den((f_n == 32'd0) ? 32'd1 : f_n),
            .in_tag({wsg, cs_vld, f_id, cs_sin, cs_cos}),
            .out_valid(q_vld[g]), .out_quo(q_quo[g]), .out_tag(q_tag[g])
        );
    end

    logic [2:0]         g_sg;
    logic               g_id;
    logic signed [34:0] g_s;
    logic signed [34:0] g_c;
    logic               g_unused;
    assign {g_sg, g_unused, g_id, g_s, g_c} = q_tag[0];

    // Stage G: clamp and sign
    logic               h_vld_reg;
    logic signed [31:0] h_u_reg [3];
    logic signed [34:0] h_s_reg;
    logic signed [34:0] h_c1_reg;
    logic               h_id_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (en)
            h_vld_reg <= q_vld[0] & g_unused;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                logic [31:0] qv;
                qv = (q_quo[i] > 63'h40000000) ? 32'h40000000 : q_quo[i][31:0];
                h_u_reg[i] <= g_sg[i] ? -$signed(qv) : $signed(qv);
            end
            h_s_reg  <= g_s;
            h_c1_reg <= ONE_Q30 - g_c;
            h_id_reg <= g_id;
        end
    end

    // Skew matrix entry m[i][j] of the unit vector
    function automatic logic signed [31:0] skew(input int i, input int j,
                                                input logic signed [31:0] ux,
                                                input logic signed [31:0] uy,
                                                input logic signed [31:0] uz);
        logic signed [31:0] v;
        v = '0;
        if (i == 0 && j == 1) v = -uz;
        if (i == 0 && j == 2) v = uy;
        if (i == 1 && j == 0) v = uz;
        if (i == 1 && j == 2) v = -ux;
        if (i == 2 && j == 0) v = -uy;
        if (i == 2 && j == 1) v = ux;
        return v;
    endfunction

    // Stage H: products u_a * u_b for U^2 (six distinct, sign folded later), and skew matrix
    logic               i_vld_reg;
    logic signed [63:0] i_pp_reg [3][3];
    logic signed [34:0] i_s_reg;
    logic signed [34:0] i_c1_reg;
    logic               i_id_reg;
    logic signed [31:0] i_m_reg [3][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (en)
            i_vld_reg <= h_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    i_pp_reg[i][j] <= h_u_reg[i] * h_u_reg[j];
                    i_m_reg[i][j]  <= skew(i, j, h_u_reg[0], h_u_reg[1], h_u_reg[2]);
                end
            i_s_reg  <= h_s_reg;
            i_c1_reg <= h_c1_reg;
            i_id_reg <= h_id_reg;
        end
    end

    // Stage I: U^2 entries. Diagonal = -(sum of other two squares), off = u_i u_j
    logic               j_vld_reg;
    logic signed [34:0] j_q_reg [3][3];
    logic signed [34:0] j_s_reg;
    logic signed [34:0] j_c1_reg;
    logic               j_id_reg;
    logic signed [31:0] j_m_reg [3][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_vld_reg <= 1'b0;
        else if (en)
            j_vld_reg <= i_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    logic signed [65:0] acc;
                    if (i == j)
                        acc = -(66'(i_pp_reg[(i+1)%3][(i+1)%3])
                                + 66'(i_pp_reg[(i+2)%3][(i+2)%3]));
                    else
                        acc = 66'(i_pp_reg[i][j]);
                    acc = acc + 66'sd536870912;
                    j_q_reg[i][j] <= 35'(acc >>> 30);
                end
            j_s_reg  <= i_s_reg;
            j_c1_reg <= i_c1_reg;
            j_id_reg <= i_id_reg;
            j_m_reg  <= i_m_reg;
        end
    end

    // Stage J: s*m and c1*q products
    logic               k_vld_reg;
    logic signed [69:0] k_a_reg [3][3];
    logic signed [69:0] k_b_reg [3][3];
    logic               k_id_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_vld_reg <= 1'b0;
        else if (en)
            k_vld_reg <= j_vld_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    k_a_reg[i][j] <= 70'(j_s_reg * 35'(j_m_reg[j][i]));
                    k_b_reg[i][j] <= 70'(j_c1_reg * j_q_reg[j][i]);
                end
            k_id_reg <= j_id_reg;
        end
    end

    // Stage K: sum, round, saturate into the output register, or identity when flagged
    logic [31:0] o_reg [9];
    logic        o_id_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= k_vld_reg;
    end
    assign tail_valid = k_vld_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    logic signed [71:0] acc;
                    logic signed [71:0] r;
                    logic signed [63:0] v;
                    acc = 72'(k_a_reg[i][j]) + 72'(k_b_reg[i][j])
                          + ((i == j) ? (72'sd1 <<< 60) : 72'sd0)
                          + 72'sd536870912;
                    r = acc >>> 30;
                    if (r > 72'(SAT_HI))
                        v = SAT_HI;
                    else if (r < 72'(SAT_LO))
                        v = SAT_LO;
                    else
                        v = r[63:0];
                    if (k_id_reg)
                        o_reg[i*3+j] <= (i == j) ? 32'h40000000 : 32'd0;
                    else
                        o_reg[i*3+j] <= v[31:0];
                end
            o_id_reg <= k_id_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign r11 = o_reg[0];
    assign r12 = o_reg[1];
    assign r13 = o_reg[2];
    assign r21 = o_reg[3];
    assign r22 = o_reg[4];
    assign r23 = o_reg[5];
    assign r31 = o_reg[6];
    assign r32 = o_reg[7];
    assign r33 = o_reg[8];
    assign is_identity = o_id_reg & tail_valid | o_id_reg;
endmodule
